### hdl/i2r_pkg.sv
// Package: numeral step table and letter codes for the integer to Roman numeral block.
package i2r_pkg;

  localparam int unsigned NumW    = 12;
  localparam int unsigned LetterW = 7;
  localparam int unsigned IdxW    = 4;

  localparam logic [NumW-1:0] NumMax = 12'd3999;

  localparam logic [LetterW-1:0] ChM = 7'h4D;
  localparam logic [LetterW-1:0] ChD = 7'h44;
  localparam logic [LetterW-1:0] ChC = 7'h43;
  localparam logic [LetterW-1:0] ChL = 7'h4C;
  localparam logic [LetterW-1:0] ChX = 7'h58;
  localparam logic [LetterW-1:0] ChV = 7'h56;
  localparam logic [LetterW-1:0] ChI = 7'h49;
  localparam logic [LetterW-1:0] ChNone = 7'h00;

  typedef struct packed {
    logic [NumW-1:0]    weight;
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
    logic               pair;
  } step_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  function automatic step_t step_lookup(input logic [IdxW-1:0] idx);
    step_t s;
    s = '{weight: 12'd1, first: ChI, second: ChNone, pair: 1'b0};
    case (idx)
      4'd0:  s = '{weight: 12'd1000, first: ChM, second: ChNone, pair: 1'b0};
      4'd1:  s = '{weight: 12'd900,  first: ChC, second: ChM,    pair: 1'b1};
      4'd2:  s = '{weight: 12'd500,  first: ChD, second: ChNone, pair: 1'b0};
      4'd3:  s = '{weight: 12'd400,  first: ChC, second: ChD,    pair: 1'b1};
      4'd4:  s = '{weight: 12'd100,  first: ChC, second: ChNone, pair: 1'b0};
      4'd5:  s = '{weight: 12'd90,   first: ChX, second: ChC,    pair: 1'b1};
      4'd6:  s = '{weight: 12'd50,   first: ChL, second: ChNone, pair: 1'b0};
      4'd7:  s = '{weight: 12'd40,   first: ChX, second: ChL,    pair: 1'b1};
      4'd8:  s = '{weight: 12'd10,   first: ChX, second: ChNone, pair: 1'b0};
      4'd9:  s = '{weight: 12'd9,    first: ChI, second: ChX,    pair: 1'b1};
      4'd10: s = '{weight: 12'd5,    first: ChV, second: ChNone, pair: 1'b0};
      4'd11: s = '{weight: 12'd4,    first: ChI, second: ChV,    pair: 1'b1};
      4'd12: s = '{weight: 12'd1,    first: ChI, second: ChNone, pair: 1'b0};
      default: s = '{weight: 12'd1,  first: ChI, second: ChNone, pair: 1'b0};
    endcase
    return s;
  endfunction

endpackage

### hdl/integer_to_roman_numeral.sv
// Top level: converts a 12-bit integer into a serial run of Roman numeral ASCII letters.
//
// Usage: drive number_i and pulse start_i while busy_o is low; the word is
// taken at that clock edge and, for a nonzero word, busy_o rises until the
// numeral is finished. Each letter appears on letter_o for one cycle with
// strobe_o high; last_o marks the final letter. A zero input gives one word
// with empty_res_o and last_o set and letter_o zero. Inputs above 3999 are
// clamped to 3999. Conversion is greedy over a 13-entry step table (1000,
// 900, ... 4, 1) with one shared compare/subtract unit: each cycle either
// emits one letter or moves to the next table entry. Letters are registered
// before they reach letter_o; a new word is taken only once the numeral is
// finished and busy_o is low. The receiver cannot stall; every strobe is a
// delivered word. Reset clears the sequencer and the strobe; the block is
// idle and ready right after reset.
module integer_to_roman_numeral (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] number_i,
  output logic        busy_o,
  output logic        strobe_o,
  output logic [6:0]  letter_o,
  output logic        last_o,
  output logic        empty_res_o
);

  i2r_pkg::state_e               state_q, state_d;
  logic [i2r_pkg::NumW-1:0]      value_q, value_d;
  logic [i2r_pkg::IdxW-1:0]      idx_q, idx_d;
  logic                          half_q, half_d;
  logic                          strobe_q, strobe_d;
  logic [i2r_pkg::LetterW-1:0]   letter_q, letter_d;
  logic                          last_q, last_d;
  logic                          empty_q, empty_d;

  i2r_pkg::step_t                step;
  logic                          fits;
  logic [i2r_pkg::NumW-1:0]      diff;

  assign step = i2r_pkg::step_lookup(idx_q);
  assign fits = (value_q >= step.weight);
  assign diff = value_q - step.weight;

  always_comb begin
    state_d  = state_q;
    value_d  = value_q;
    idx_d    = idx_q;
    half_d   = half_q;
    strobe_d = 1'b0;
    letter_d = letter_q;
    last_d   = last_q;
    empty_d  = empty_q;
    case (state_q)
      i2r_pkg::StIdle: begin
        if (start_i) begin
          idx_d  = '0;
          half_d = 1'b0;
          if (number_i == '0) begin
            strobe_d = 1'b1;
            letter_d = i2r_pkg::ChNone;
            last_d   = 1'b1;
            empty_d  = 1'b1;
          end else begin
            value_d = (number_i > i2r_pkg::NumMax) ? i2r_pkg::NumMax : number_i;
            state_d = i2r_pkg::StRun;
          end
        end
      end
      i2r_pkg::StRun: begin
        empty_d = 1'b0;
        if (half_q) begin
          // second letter of a subtractive pair
          strobe_d = 1'b1;
          letter_d = step.second;
          last_d   = (diff == '0);
          value_d  = diff;
          half_d   = 1'b0;
          if (diff == '0) state_d = i2r_pkg::StIdle;
        end else if (fits) begin
          strobe_d = 1'b1;
          letter_d = step.first;
          if (step.pair) begin
            last_d = 1'b0;
            half_d = 1'b1;
          end else begin
            last_d  = (diff == '0);
            value_d = diff;
            if (diff == '0) state_d = i2r_pkg::StIdle;
          end
        end else begin
          idx_d = idx_q + i2r_pkg::IdxW'(1);
        end
      end
      default: state_d = i2r_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= i2r_pkg::StIdle;
      strobe_q <= 1'b0;
      half_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      half_q   <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    idx_q    <= idx_d;
    letter_q <= letter_d;
    last_q   <= last_d;
    empty_q  <= empty_d;
  end

  assign busy_o      = (state_q != i2r_pkg::StIdle);
  assign strobe_o    = strobe_q;
  assign letter_o    = letter_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

endmodule
